FILE: rtl/core/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

	localparam int REGION_GRANULES = 4096;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ZERO  = 2'd1;
	localparam logic [1:0] ST_NOFIT = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LOOK,
		S_CHECK,
		S_APPLY,
		S_OUT
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic start;    // latch request, start scan
		logic scan;     // advance scan by one entry
		logic look;     // read length store
		logic check;    // evaluate free checks
		logic apply;    // commit table update
		logic fail;     // load failure result
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic is_alloc;
		logic early_fail;
		logic late_fail;
	} dp_stat_t;

endpackage

FILE: rtl/core/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module ffra_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Request sequencer: scan, length lookup and check (frees only), apply, output.
// ----------------------------------------------------------------------------
module ffra_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ffra_pkg::dp_stat_t  stat,
	output ffra_pkg::ctl_cmd_t  cmd
);
	import ffra_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.early_fail) begin
					cmd.fail = 1'b1;
					state_d = S_OUT;
				end else if (stat.scan_done) begin
					state_d = stat.is_alloc ? S_APPLY : S_LOOK;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d = S_APPLY;
			end
			S_APPLY: begin
				if (stat.late_fail) begin
					cmd.fail = 1'b1;
				end else begin
					cmd.apply = 1'b1;
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

FILE: rtl/core/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp
// Extent table, length store, scan and update datapath.
// ----------------------------------------------------------------------------
module ffra_dp #(
	parameter int MAX_FREE_EXTENTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [16:0]        cfg_wdata,
	input  logic               op,
	input  logic [15:0]        req,
	input  logic [15:0]        rel,
	input  ffra_pkg::ctl_cmd_t cmd,
	output ffra_pkg::dp_stat_t stat,
	output logic [1:0]         status,
	output logic [15:0]        granted_offset,
	output logic [16:0]        free_bytes
);
	import ffra_pkg::*;

	localparam int GW = $clog2(REGION_GRANULES) + 1;
	localparam int AW = $clog2(REGION_GRANULES);
	localparam int IW = $clog2(MAX_FREE_EXTENTS);
	localparam int CW = $clog2(MAX_FREE_EXTENTS + 1);
	localparam int LW = AW;
	localparam int N  = MAX_FREE_EXTENTS;

	logic [GW-1:0] st_q  [N];
	logic [GW-1:0] len_q [N];
	logic [CW-1:0] cnt_q;
	logic [16:0]   total_q;
	logic [GW-1:0] rgran_q;

	logic          op_s1;
	logic [GW-1:0] need_q;
	logic [GW-1:0] g_q;
	logic [CW-1:0] idx_q;
	logic          found_q;
	logic [IW-1:0] fidx_q;
	logic [CW-1:0] p_q;
	logic [GW-1:0] blen_q;
	logic          bad_q;
	logic          zero_q;
	logic [1:0]    fst_q;

	logic [1:0]    st_out_q;
	logic [15:0]   off_out_q;

	// length store
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [LW-1:0] ram_wdata;
	logic [LW-1:0] ram_rdata;
	logic [LW-1:0] ram_wzero;

	assign ram_wzero = '0;

	ffra_ram #(.WIDTH(LW), .DEPTH(REGION_GRANULES)) u_len_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(g_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// region granules from config
	logic [16:0] cfg_g;
	logic [GW-1:0] cfg_gran;
	always_comb begin
		cfg_g = {4'd0, cfg_wdata[16:4]};
		if (cfg_g > 17'(REGION_GRANULES)) begin
			cfg_gran = GW'(REGION_GRANULES);
		end else if (cfg_g < 17'd2) begin
			cfg_gran = GW'(2);
		end else begin
			cfg_gran = GW'(cfg_g);
		end
	end

	// request decode
	logic [16:0]   need_c;
	logic [GW-1:0] need_gc;
	logic [16:0]   need_full;
	always_comb begin
		need_c = (req < 16'd8) ? 17'd1 : ((17'(req) + 17'd23) >> 4);
		need_gc = GW'(need_c);
		need_full = need_c;
	end

	// current scan entry
	logic [IW-1:0] cur;
	logic [GW-1:0] cur_s, cur_l;
	logic [GW:0]   blk_e;
	logic          scan_end;
	assign cur = idx_q[IW-1:0];
	assign cur_s = st_q[cur];
	assign cur_l = len_q[cur];
	assign blk_e = {1'b0, g_q} + {1'b0, blen_q};
	assign scan_end = (idx_q >= cnt_q);

	assign stat.is_alloc = (op_s1 == OP_ALLOC);
	assign stat.scan_done = scan_end || (op_s1 == OP_ALLOC && found_q);
	assign stat.early_fail = bad_q;

	// merge decision
	logic [IW-1:0] pm1, pi;
	logic          mp, mn;
	logic [GW-1:0] prev_l_new, next_l_new;
	assign pm1 = IW'(p_q - CW'(1));
	assign pi  = p_q[IW-1:0];
	assign mp = (p_q != '0) && ({1'b0, st_q[pm1]} + {1'b0, len_q[pm1]} == {1'b0, g_q});
	assign mn = (p_q < cnt_q) && (blk_e == {1'b0, st_q[pi]});
	assign prev_l_new = len_q[pm1] + blen_q + (mn ? len_q[pi] : '0);
	assign next_l_new = len_q[pi] + blen_q;

	// full only matters if no merge
	logic [1:0] late_st;
	always_comb begin
		if (op_s1 == OP_ALLOC) begin
			late_st = ST_NOFIT;
		end else if (fst_q == ST_FULL && (mp || mn)) begin
			late_st = ST_OK;
		end else begin
			late_st = fst_q;
		end
	end

	assign stat.late_fail = (op_s1 == OP_ALLOC) ? !found_q : (late_st != ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				st_q[k]  <= (k == 0) ? GW'(1) : '0;
				len_q[k] <= (k == 0) ? GW'(REGION_GRANULES - 1) : '0;
			end
			cnt_q   <= CW'(1);
			total_q <= 17'((REGION_GRANULES - 1) * 16);
			rgran_q <= GW'(REGION_GRANULES);
		end else if (cfg_we) begin
			for (int k = 0; k < N; k++) begin
				st_q[k]  <= (k == 0) ? GW'(1) : '0;
				len_q[k] <= (k == 0) ? cfg_gran - GW'(1) : '0;
			end
			cnt_q   <= CW'(1);
			total_q <= 17'({cfg_gran - GW'(1), 4'd0});
			rgran_q <= cfg_gran;
		end else if (cmd.apply) begin
			if (op_s1 == OP_ALLOC) begin
				total_q <= total_q - {need_q, 4'd0};
				if (len_q[fidx_q] == need_q) begin
					for (int k = 0; k < N; k++) begin
						if (k >= int'(fidx_q) && k + 1 < int'(cnt_q)) begin
							st_q[k]  <= st_q[(k + 1) % N];
							len_q[k] <= len_q[(k + 1) % N];
						end else if (k + 1 == int'(cnt_q)) begin
							st_q[k]  <= '0;
							len_q[k] <= '0;
						end
					end
					cnt_q <= cnt_q - CW'(1);
				end else begin
					st_q[fidx_q]  <= st_q[fidx_q] + need_q;
					len_q[fidx_q] <= len_q[fidx_q] - need_q;
				end
			end else begin
				total_q <= total_q + 17'({blen_q, 4'd0});
				if (mp && mn) begin
					len_q[pm1] <= prev_l_new;
					for (int k = 0; k < N; k++) begin
						if (k >= int'(pi) && k + 1 < int'(cnt_q)) begin
							st_q[k]  <= st_q[(k + 1) % N];
							len_q[k] <= len_q[(k + 1) % N];
						end else if (k + 1 == int'(cnt_q)) begin
							st_q[k]  <= '0;
							len_q[k] <= '0;
						end
					end
					cnt_q <= cnt_q - CW'(1);
				end else if (mp) begin
					len_q[pm1] <= prev_l_new;
				end else if (mn) begin
					st_q[pi]  <= g_q;
					len_q[pi] <= next_l_new;
				end else begin
					for (int k = 0; k < N; k++) begin
						if (k > int'(pi) && k <= int'(cnt_q)) begin
							st_q[k]  <= st_q[(k + N - 1) % N];
							len_q[k] <= len_q[(k + N - 1) % N];
						end else if (k == int'(pi)) begin
							st_q[k]  <= g_q;
							len_q[k] <= blen_q;
						end
					end
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	// length store write on commit
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = g_q[AW-1:0];
		ram_wdata = ram_wzero;
		if (cmd.apply) begin
			ram_we = 1'b1;
			if (op_s1 == OP_ALLOC) begin
				ram_waddr = st_q[fidx_q][AW-1:0];
				ram_wdata = need_q[LW-1:0];
				ram_we = (st_q[fidx_q] < GW'(REGION_GRANULES));
			end
		end
	end

	// free checks on the stored length
	logic          ovl_c;
	logic [GW-1:0] ln;
	logic [GW:0]   be;
	always_comb begin
		ln = GW'(ram_rdata);
		be = {1'b0, g_q} + {1'b0, ln};
		ovl_c = 1'b0;
		for (int k = 0; k < N; k++) begin
			if (k < int'(cnt_q)) begin
				if ({1'b0, g_q} < {1'b0, st_q[k]} + {1'b0, len_q[k]}
						&& {1'b0, st_q[k]} < be) begin
					ovl_c = 1'b1;
				end
			end
		end
	end

	// request registers and scan
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_s1   <= op;
			need_q  <= need_gc;
			g_q     <= GW'(rel[15:4]);
			idx_q   <= '0;
			found_q <= 1'b0;
			fidx_q  <= '0;
			p_q     <= '0;
			fst_q   <= ST_OK;
			zero_q  <= (req == 16'd0);
			if (op == OP_ALLOC) begin
				bad_q <= (req == 16'd0) || (need_c > 17'(total_q >> 4))
					|| ({need_full[12:0], 4'd0} > total_q)
					|| (need_c > 17'(REGION_GRANULES - 1));
			end else begin
				bad_q <= (rel[3:0] != 4'd8) || (rel[15:4] == 12'd0)
					|| (GW'(rel[15:4]) >= rgran_q);
			end
		end else if (cmd.scan) begin
			idx_q <= idx_q + CW'(1);
			if (op_s1 == OP_ALLOC) begin
				if (cur_l >= need_q) begin
					found_q <= 1'b1;
					fidx_q  <= cur;
				end
			end else if (cur_s <= g_q) begin
				p_q <= idx_q + CW'(1);
			end
		end else if (cmd.look) begin
			blen_q <= '0;
		end else if (cmd.check) begin
			blen_q <= GW'(ram_rdata);
			if (ln == '0 || be > {1'b0, rgran_q} || ovl_c) begin
				fst_q <= ST_ZERO;
			end else if (cnt_q >= CW'(N)) begin
				fst_q <= ST_FULL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fail) begin
			if (bad_q) begin
				if (op_s1 == OP_ALLOC) begin
					st_out_q <= zero_q ? ST_ZERO : ST_NOFIT;
				end else begin
					st_out_q <= ST_ZERO;
				end
			end else begin
				st_out_q <= late_st;
			end
			off_out_q <= '0;
		end else if (cmd.apply) begin
			st_out_q <= ST_OK;
			off_out_q <= (op_s1 == OP_ALLOC) ? {st_q[fidx_q][11:0], 4'd8} : '0;
		end
	end

	assign status = st_out_q;
	assign granted_offset = off_out_q;
	assign free_bytes = total_q;
endmodule

FILE: rtl/core/first_fit_region_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit allocator over 16-byte granules with free-extent coalescing.
//
//   channel  signals                                     dir
//   in       in_valid/in_ready, operation, request_bytes,
//            release_offset                              in
//   out      out_valid/out_ready, status, granted_offset,
//            free_bytes                                  out
//   cfg      cfg_we, cfg_wdata (region_bytes)            in
//
// An allocate scans the extent table up to the first fit; a free scans all
// extents, then reads the stored block length and checks it.
// Reset restores a 64 KiB region. The result holds until out_ready.
// ----------------------------------------------------------------------------
module first_fit_region_allocator #(
	parameter int MAX_FREE_EXTENTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [15:0] request_bytes,
	input  logic [15:0] release_offset,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] granted_offset,
	output logic [16:0] free_bytes
);
	import ffra_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	ffra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffra_dp #(
		.MAX_FREE_EXTENTS(MAX_FREE_EXTENTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.op            (operation),
		.req           (request_bytes),
		.rel           (release_offset),
		.cmd           (cmd),
		.stat          (stat),
		.status        (status),
		.granted_offset(granted_offset),
		.free_bytes    (free_bytes)
	);
endmodule

FILE: tb/sv/tb_first_fit_region_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_region_allocator
// Drives allocate and free words through the allocator under random idling
// and output stalls, and checks every reply word against a first-fit
// predictor of the free table, free total and block lengths. The region
// size is rewritten between phases, the smallest and largest among them.
// ----------------------------------------------------------------------------
module tb_first_fit_region_allocator;
	import ffra_pkg::*;

	localparam int NEXT = 16;
	localparam int NGRAN = 4096;

	typedef struct {
		logic [1:0]  st;
		logic [15:0] offset;
		logic [16:0] free_total;
	} reply_t;

	class region_book;
		int unsigned ext_start[NEXT];
		int unsigned ext_len[NEXT];
		int unsigned ext_cnt;
		int unsigned free_total;
		int unsigned gran_cnt;
		int unsigned block_len[NGRAN];
		bit          len_written[NGRAN];
		int unsigned live_blocks[$];
		reply_t      expected_replies[$];
		int          errors;

		function new();
			foreach (block_len[i]) begin
				block_len[i] = 0;
				len_written[i] = 0;
			end
			errors = 0;
			set_region(17'd65536);
		endfunction

		function void set_region(logic [16:0] bytes);
			int unsigned g;
			g = bytes >> 4;
			if (g > NGRAN) g = NGRAN;
			if (g < 2) g = 2;
			gran_cnt = g;
			foreach (ext_start[i]) begin
				ext_start[i] = 0;
				ext_len[i] = 0;
			end
			ext_start[0] = 1;
			ext_len[0] = g - 1;
			ext_cnt = 1;
			free_total = (g - 1) * 16;
			live_blocks.delete();
		endfunction

		function void drop_extent(int unsigned i);
			for (int unsigned k = i; k + 1 < ext_cnt; k++) begin
				ext_start[k] = ext_start[k + 1];
				ext_len[k] = ext_len[k + 1];
			end
			ext_cnt--;
			ext_start[ext_cnt] = 0;
			ext_len[ext_cnt] = 0;
		endfunction

		function logic [1:0] grant(int unsigned bytes, output int unsigned offset);
			int unsigned need, s;
			offset = 0;
			if (bytes == 0) return ST_ZERO;
			need = (bytes < 8) ? 1 : ((bytes + 23) >> 4);
			if (need * 16 > free_total) return ST_NOFIT;
			for (int unsigned i = 0; i < ext_cnt; i++) begin
				if (ext_len[i] >= need) begin
					s = ext_start[i];
					if (ext_len[i] == need) drop_extent(i);
					else begin
						ext_start[i] = s + need;
						ext_len[i] -= need;
					end
					if (s < NGRAN) begin
						block_len[s] = need;
						len_written[s] = 1;
					end
					free_total -= need * 16;
					offset = (s * 16 + 8) & 16'hFFFF;
					live_blocks.push_back(s);
					return ST_OK;
				end
			end
			return ST_NOFIT;
		endfunction

		function logic [1:0] release_block(int unsigned off);
			int unsigned g, len, p, s, e;
			bit mp, mn;
			if ((off & 15) != 8) return ST_ZERO;
			g = off >> 4;
			if (g == 0 || g >= gran_cnt || g >= NGRAN) return ST_ZERO;
			len = block_len[g];
			if (len == 0 || g + len > gran_cnt) return ST_ZERO;
			for (int unsigned i = 0; i < ext_cnt; i++) begin
				s = ext_start[i];
				e = s + ext_len[i];
				if (g < e && s < g + len) return ST_ZERO;
			end
			p = 0;
			while (p < ext_cnt && ext_start[p] <= g) p++;
			mp = (p > 0) && (ext_start[p - 1] + ext_len[p - 1] == g);
			mn = (p < ext_cnt) && (g + len == ext_start[p]);
			if (mp && mn) begin
				ext_len[p - 1] += len + ext_len[p];
				drop_extent(p);
			end else if (mp) begin
				ext_len[p - 1] += len;
			end else if (mn) begin
				ext_start[p] = g;
				ext_len[p] += len;
			end else begin
				if (ext_cnt >= NEXT) return ST_FULL;
				for (int unsigned i = ext_cnt; i > p; i--) begin
					ext_start[i] = ext_start[i - 1];
					ext_len[i] = ext_len[i - 1];
				end
				ext_start[p] = g;
				ext_len[p] = len;
				ext_cnt++;
			end
			block_len[g] = 0;
			free_total += len * 16;
			foreach (live_blocks[i]) begin
				if (live_blocks[i] == g) begin
					live_blocks.delete(i);
					break;
				end
			end
			return ST_OK;
		endfunction

		function void note_request(logic op, logic [15:0] req, logic [15:0] rel);
			reply_t r;
			int unsigned off;
			off = 0;
			if (op == OP_ALLOC) r.st = grant(req, off);
			else r.st = release_block(rel);
			r.offset = (r.st == ST_OK) ? off[15:0] : 16'd0;
			r.free_total = free_total[16:0];
			expected_replies.push_back(r);
		endfunction

		task report_mismatch(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_reply(logic [1:0] st, logic [15:0] off, logic [16:0] fb);
			reply_t r;
			if (expected_replies.size() == 0) begin
				report_mismatch($sformatf("unexpected word st=%0d off=%0h", st, off));
				return;
			end
			r = expected_replies.pop_front();
			if (st !== r.st)
				report_mismatch($sformatf("status %0d, want %0d", st, r.st));
			if (off !== r.offset)
				report_mismatch($sformatf("offset %0h, want %0h", off, r.offset));
			if (fb !== r.free_total)
				report_mismatch($sformatf("free %0d, want %0d", fb, r.free_total));
		endtask

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [16:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [15:0] request_bytes;
	logic [15:0] release_offset;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [15:0] granted_offset;
	logic [16:0] free_bytes;

	region_book book;
	bit         steady;
	int         sent;

	first_fit_region_allocator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.request_bytes (request_bytes),
		.release_offset(release_offset),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_offset(granted_offset),
		.free_bytes    (free_bytes)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_reply(status, granted_offset, free_bytes);
		out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 37);
	end

	task send_word(logic op, logic [15:0] req, logic [15:0] rel);
		if (!steady && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		request_bytes <= req;
		release_offset <= rel;
		do @(posedge clk); while (!in_ready);
		book.note_request(op, req, rel);
		sent++;
	endtask

	task write_region(logic [16:0] bytes);
		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_wdata <= bytes;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.set_region(bytes);
	endtask

	function logic [15:0] pick_release();
		int unsigned r, g, o;
		r = $urandom_range(99);
		if (r < 70 && book.live_blocks.size() != 0)
			return 16'(book.live_blocks[$urandom_range(book.live_blocks.size() - 1)] * 16
				+ 8);
		if (r < 80) begin
			for (int k = 0; k < 8; k++) begin
				g = $urandom_range(NGRAN - 1);
				if (book.len_written[g]) return 16'(g * 16 + 8);
			end
			return 16'd8;
		end
		if (r < 92) begin
			o = $urandom_range(16'hFFFF);
			if ((o & 15) == 8) o ^= 1;
			return 16'(o);
		end
		if (book.gran_cnt < NGRAN)
			return 16'($urandom_range(NGRAN - 1, book.gran_cnt) * 16 + 8);
		return 16'd8;
	endfunction

	function logic [15:0] pick_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) return 16'($urandom_range(64, 1));
		if (r < 85) return 16'($urandom_range(600, 65));
		if (r < 95) return 16'($urandom_range(7));
		return 16'($urandom_range(16'hFFFF));
	endfunction

	task random_items(int n);
		int free_pct;
		for (int i = 0; i < n; i++) begin
			steady = (i >= n / 3 && i < n / 2);
			free_pct = (book.live_blocks.size() > 30) ? 60 : 40;
			if ($urandom_range(99) < free_pct)
				send_word(OP_FREE, 16'($urandom_range(16'hFFFF)), pick_release());
			else
				send_word(OP_ALLOC, pick_size(), 16'($urandom_range(16'hFFFF)));
		end
		steady = 0;
	endtask

	initial begin
		logic [16:0] regions [6];
		book = new();
		steady = 0;
		sent = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		in_valid = 0;
		operation = OP_ALLOC;
		request_bytes = '0;
		release_offset = '0;
		out_ready = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_ALLOC, 16'd0, 16'hFFFF);
		send_word(OP_ALLOC, 16'd1, 16'h0000);
		send_word(OP_ALLOC, 16'd7, 16'h1234);
		send_word(OP_ALLOC, 16'd8, 16'hFFFF);
		send_word(OP_ALLOC, 16'd9, 16'h0);
		send_word(OP_ALLOC, 16'hFFFF, 16'h0);
		send_word(OP_FREE, 16'hFFFF, 16'h0001);
		send_word(OP_FREE, 16'h0, 16'd8);
		send_word(OP_FREE, 16'h0, 16'd24);
		send_word(OP_FREE, 16'h0, 16'd24);
		send_word(OP_FREE, 16'h0, 16'd56);

		write_region(17'd32);
		send_word(OP_ALLOC, 16'd3, 16'h0);
		send_word(OP_ALLOC, 16'd1, 16'h0);
		send_word(OP_FREE, 16'h0, 16'h0FF8);
		send_word(OP_FREE, 16'h0, 16'd24);

		// fill the free table: many unit blocks, release every other one
		write_region(17'd1024);
		for (int i = 0; i < 40; i++) send_word(OP_ALLOC, 16'd4, 16'h0);
		for (int i = 0; i < 19; i++) send_word(OP_FREE, 16'h0, 16'((1 + 2 * i) * 16 + 8));

		regions[0] = 17'd65536;
		regions[1] = 17'd32;
		regions[2] = 17'd65535;
		regions[3] = 17'd1000;
		regions[4] = 17'($urandom_range(65536, 32));
		regions[5] = 17'($urandom_range(8000, 200));
		foreach (regions[i]) begin
			write_region(regions[i]);
			random_items(i == 1 ? 60 : 300);
		end

		in_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (book.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/ffra_pkg.sv
rtl/core/ffra_ram.sv
rtl/core/ffra_ctrl.sv
rtl/core/ffra_dp.sv
rtl/core/first_fit_region_allocator.sv
tb/sv/tb_first_fit_region_allocator.sv
